// ----- hdl/tts_pkg.sv -----
// Shared types and constants for the tick task slot scheduler.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package tts_pkg;

    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int PTR_W       = $clog2(SLOTS);
    localparam int SLOT_W      = $clog2(SLOTS + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(SLOTS);
    localparam logic [7:0]        RUNS_MAX  = 8'd255;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_DISP   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_BAD_DELETE = 3'd2;
    localparam logic [2:0] ST_NONE_READY = 3'd3;
    localparam logic [2:0] ST_RUN        = 3'd4;

    // error register codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_FULL   = 2'd1;
    localparam logic [1:0] ERR_DELETE = 2'd2;

    typedef enum logic {
        UOP_TICK,
        UOP_DISP
    } uop_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  task_handle;
        logic [31:0] first_delay;
        logic [31:0] repeat_period;
        logic [3:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] slot_out;
        logic [7:0] handle_out;
        logic       last_flag;
        logic [1:0] sticky_error;
    } res_t;

    typedef struct packed {
        logic        used;
        logic [7:0]  handle;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  runs;
    } slot_t;

    // what the slot unit reports back to the sequencer
    typedef struct packed {
        slot_t entry;
        logic  fire;
    } unit_out_t;

endpackage

// ----- hdl/tts_slot_unit.sv -----
// Shared per-slot update unit: ages one slot on a tick or serves one slot on a dispatch.
// Depends on tts_pkg.
`timescale 1ns / 1ps

module tts_slot_unit
(
    input  tts_pkg::uop_t      op,
    input  tts_pkg::slot_t     entry,
    input  logic               allow,
    output tts_pkg::unit_out_t result
);

    always_comb
    begin
        result.entry = entry;
        result.fire  = 1'b0;
        unique case (op)
            tts_pkg::UOP_TICK:
            begin
                if (entry.used)
                begin
                    if (entry.delay == 32'd0)
                    begin
                        if (entry.runs != tts_pkg::RUNS_MAX)
                            result.entry.runs = entry.runs + 8'd1;
                        if (entry.period != 32'd0)
                            result.entry.delay = entry.period;
                    end
                    else
                    begin
                        result.entry.delay = entry.delay - 32'd1;
                    end
                end
            end
            tts_pkg::UOP_DISP:
            begin
                if (entry.runs != 8'd0 && allow)
                begin
                    if (entry.used)
                    begin
                        result.fire       = 1'b1;
                        result.entry.runs = entry.runs - 8'd1;
                        if (entry.period == 32'd0)
                            result.entry = '0;
                    end
                    else
                    begin
                        result.entry = '0;
                    end
                end
            end
            default:
            begin
                result.entry = entry;
            end
        endcase
    end

endmodule

// ----- hdl/tick_task_slot_scheduler_top.sv -----
// Top level of the tick task slot scheduler: request sequencer and slot table.
// Depends on tts_pkg and tts_slot_unit.
`timescale 1ns / 1ps

// Channel   Signals               Direction  Handshake
// --------  --------------------  ---------  ----------------------------------
// request   start, busy, req      in         taken when start is high, busy low
// result    done, result          out        one-cycle strobe per item, no back-pressure
//
// Steps: add searches for the lowest free slot, delete clears the indexed slot
// if it is in range, tick ages one slot per cycle through the shared slot unit,
// dispatch scans every slot through the same unit; the request is registered first.
// Reset clears every slot and the error register at once; no clearing pass.
// busy stays high from the accepting edge until the final result is shown.
// The receiver cannot stall: each result is valid for exactly one cycle.

module tick_task_slot_scheduler_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  tts_pkg::req_t req,
    output logic          done,
    output tts_pkg::res_t result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DEL,
        S_TICK,
        S_DISP,
        S_FINISH
    } state_t;

    state_t                      state_reg, state_next;
    tts_pkg::req_t               req_reg, req_next;
    logic [tts_pkg::PTR_W-1:0]   ptr_reg, ptr_next;
    logic [tts_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]                  err_reg, err_next;
    logic                        hold_valid_reg, hold_valid_next;
    logic [tts_pkg::PTR_W-1:0]   hold_slot_reg, hold_slot_next;
    logic [7:0]                  hold_handle_reg, hold_handle_next;
    logic                        done_reg, done_next;
    tts_pkg::res_t               res_reg, res_next;

    tts_pkg::slot_t              slot_reg [tts_pkg::SLOTS];
    tts_pkg::slot_t              cur;
    tts_pkg::slot_t              wr_data;
    logic                        wr_en;

    tts_pkg::uop_t               uop;
    tts_pkg::unit_out_t          unit_res;
    logic                        at_last;

    function automatic tts_pkg::res_t mk_res(
        input logic [2:0] status,
        input logic [4:0] slot,
        input logic [7:0] handle,
        input logic       last,
        input logic [1:0] err
    );
        tts_pkg::res_t r;
        r.status       = status;
        r.slot_out     = slot;
        r.handle_out   = handle;
        r.last_flag    = last;
        r.sticky_error = err;
        return r;
    endfunction

    // every slot access goes through the single pointer
    assign cur     = slot_reg[ptr_reg];
    assign at_last = (ptr_reg == tts_pkg::PTR_W'(tts_pkg::SLOTS - 1));
    assign uop     = (state_reg == S_TICK) ? tts_pkg::UOP_TICK : tts_pkg::UOP_DISP;

    tts_slot_unit u_unit
    (
        .op     (uop),
        .entry  (cur),
        .allow  (cnt_reg < tts_pkg::CNT_W'(tts_pkg::MAX_RESULTS)),
        .result (unit_res)
    );

    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        ptr_next         = ptr_reg;
        cnt_next         = cnt_reg;
        err_next         = err_reg;
        hold_valid_next  = hold_valid_reg;
        hold_slot_next   = hold_slot_reg;
        hold_handle_next = hold_handle_reg;
        done_next        = 1'b0;
        res_next         = res_reg;
        wr_en            = 1'b0;
        wr_data          = cur;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next        = req;
                    cnt_next        = '0;
                    hold_valid_next = 1'b0;
                    ptr_next        = '0;
                    unique case (req.req_type)
                        tts_pkg::REQ_ADD:    state_next = S_ADD;
                        tts_pkg::REQ_DELETE:
                        begin
                            ptr_next   = req.slot_index[tts_pkg::PTR_W-1:0];
                            state_next = S_DEL;
                        end
                        tts_pkg::REQ_TICK:   state_next = S_TICK;
                        tts_pkg::REQ_DISP:   state_next = S_DISP;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end

            S_ADD:
            begin
                if (!cur.used)
                begin
                    // take the lowest free slot
                    wr_en          = 1'b1;
                    wr_data.used   = 1'b1;
                    wr_data.handle = req_reg.task_handle;
                    wr_data.delay  = req_reg.first_delay;
                    wr_data.period = req_reg.repeat_period;
                    wr_data.runs   = 8'd0;
                    done_next      = 1'b1;
                    res_next       = mk_res(tts_pkg::ST_OK, tts_pkg::SLOT_W'(ptr_reg),
                                            8'd0, 1'b1, err_reg);
                    state_next     = S_IDLE;
                end
                else if (at_last)
                begin
                    err_next   = tts_pkg::ERR_FULL;
                    done_next  = 1'b1;
                    res_next   = mk_res(tts_pkg::ST_FULL, tts_pkg::SLOT_NONE, 8'd0, 1'b1,
                                        tts_pkg::ERR_FULL);
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + tts_pkg::PTR_W'(1);
                end
            end

            S_DEL:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (32'(req_reg.slot_index) >= tts_pkg::SLOTS)
                begin
                    // out of range: leave the table alone
                    err_next = tts_pkg::ERR_DELETE;
                    res_next = mk_res(tts_pkg::ST_BAD_DELETE,
                                      tts_pkg::SLOT_W'(req_reg.slot_index), 8'd0, 1'b1,
                                      tts_pkg::ERR_DELETE);
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                    if (cur.used)
                    begin
                        res_next = mk_res(tts_pkg::ST_OK,
                                          tts_pkg::SLOT_W'(req_reg.slot_index), 8'd0, 1'b1,
                                          err_reg);
                    end
                    else
                    begin
                        err_next = tts_pkg::ERR_DELETE;
                        res_next = mk_res(tts_pkg::ST_BAD_DELETE,
                                          tts_pkg::SLOT_W'(req_reg.slot_index), 8'd0, 1'b1,
                                          tts_pkg::ERR_DELETE);
                    end
                end
            end

            S_TICK:
            begin
                wr_en   = 1'b1;
                wr_data = unit_res.entry;
                if (at_last)
                begin
                    done_next  = 1'b1;
                    res_next   = mk_res(tts_pkg::ST_OK, tts_pkg::SLOT_NONE, 8'd0, 1'b1,
                                        err_reg);
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + tts_pkg::PTR_W'(1);
                end
            end

            S_DISP:
            begin
                wr_en   = 1'b1;
                wr_data = unit_res.entry;
                if (unit_res.fire)
                begin
                    // release the held result, not the last one; hold this slot
                    if (hold_valid_reg)
                    begin
                        done_next = 1'b1;
                        res_next  = mk_res(tts_pkg::ST_RUN,
                                           tts_pkg::SLOT_W'(hold_slot_reg),
                                           hold_handle_reg, 1'b0, err_reg);
                    end
                    hold_valid_next  = 1'b1;
                    hold_slot_next   = ptr_reg;
                    hold_handle_next = cur.handle;
                    cnt_next         = cnt_reg + tts_pkg::CNT_W'(1);
                end
                if (at_last)
                    state_next = S_FINISH;
                else
                    ptr_next = ptr_reg + tts_pkg::PTR_W'(1);
            end

            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (hold_valid_reg)
                    res_next = mk_res(tts_pkg::ST_RUN, tts_pkg::SLOT_W'(hold_slot_reg),
                                      hold_handle_reg, 1'b1, err_reg);
                else
                    res_next = mk_res(tts_pkg::ST_NONE_READY, tts_pkg::SLOT_NONE, 8'd0,
                                      1'b1, err_reg);
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer state, error register, counters and done strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            err_reg        <= tts_pkg::ERR_NONE;
            done_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            ptr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            err_reg        <= err_next;
            done_reg       <= done_next;
            hold_valid_reg <= hold_valid_next;
            cnt_reg        <= cnt_next;
            ptr_reg        <= ptr_next;
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        hold_slot_reg   <= hold_slot_next;
        hold_handle_reg <= hold_handle_next;
        res_reg         <= res_next;
    end

    // slot table: one write port at the pointer, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tts_pkg::SLOTS; i++)
                slot_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            slot_reg[ptr_reg] <= wr_data;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule
